>>> sv/dna_pkg.sv
// ----------------------------------------------------------------------------
// dna_pkg
// Types, codes and saturation helpers for the dual number arithmetic unit.
// ----------------------------------------------------------------------------
package dna_pkg;

   localparam int QBITS = 33;

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_NEG  = 3'd4,
      OP_CONJ = 3'd5,
      OP_INV  = 3'd6
   } op_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] a_real;
      logic signed [31:0] a_dual;
      logic signed [31:0] b_real;
      logic signed [31:0] b_dual;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_real;
      logic signed [31:0] res_dual;
      logic               div_zero;
      logic               overflow;
   } rsp_type;

   // sign, truncated magnitude, and flag for magnitude beyond 33 bits
   typedef struct packed {
      logic             neg;
      logic [QBITS-1:0] mag;
      logic             big;
   } part_type;

   function automatic part_type mag_part(input logic signed [65:0] v, input int unsigned sh);
      logic [65:0] m;
      part_type    p;
      m     = v[65] ? 66'(-v) : 66'(v);
      m     = m >> sh;
      p.neg = v[65];
      p.mag = m[QBITS-1:0];
      p.big = |m[65:QBITS];
      return p;
   endfunction

   // returns {overflow, value}
   function automatic logic [32:0] sat32(input part_type p);
      logic [QBITS-1:0] nm;
      logic [32:0]      r;
      nm = QBITS'(~p.mag) + QBITS'(1);
      if (p.big) begin
         r = {1'b1, p.neg ? Q_MIN : Q_MAX};
      end else if (p.neg) begin
         if (p.mag > QBITS'(Q_MIN)) r = {1'b1, Q_MIN};
         else                        r = {1'b0, nm[31:0]};
      end else begin
         if (p.mag > QBITS'(Q_MAX)) r = {1'b1, Q_MAX};
         else                        r = {1'b0, p.mag[31:0]};
      end
      return r;
   endfunction

endpackage

>>> sv/dna_divider.sv
// ----------------------------------------------------------------------------
// dna_divider
// Pipelined restoring divider, one quotient bit per stage, 33-bit quotient
// with a flag for quotients of 2^33 and above.
// ----------------------------------------------------------------------------
module dna_divider #(
   parameter int NW = 56,
   parameter int DW = 32
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [NW-1:0]          n,
   input  logic [DW-1:0]          d,
   output logic [dna_pkg::QBITS-1:0] q,
   output logic                   big
);
   import dna_pkg::*;

   logic [DW-1:0]    r_ff   [0:QBITS];
   logic [QBITS-1:0] nlo_ff [0:QBITS];
   logic [QBITS-1:0] q_ff   [0:QBITS];
   logic [DW-1:0]    d_ff   [0:QBITS];
   logic             big_ff [0:QBITS];

   logic [NW-1:0] hi;
   assign hi = n >> QBITS;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= hi[DW-1:0];
         nlo_ff[0] <= n[QBITS-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= d;
         big_ff[0] <= hi >= NW'(d);
      end
   end

   for (genvar k = 1; k <= QBITS; k++) begin : g_stage
      localparam int B = QBITS - k;
      logic [DW:0]   t_in;
      logic          ge_in;
      logic [DW:0]   dif_in;
      assign t_in   = {r_ff[k-1], nlo_ff[k-1][B]};
      assign ge_in  = t_in >= {1'b0, d_ff[k-1]};
      assign dif_in = t_in - {1'b0, d_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= ge_in ? dif_in[DW-1:0] : t_in[DW-1:0];
            q_ff[k]   <= ge_in ? (q_ff[k-1] | (QBITS'(1) << B)) : q_ff[k-1];
            nlo_ff[k] <= nlo_ff[k-1];
            d_ff[k]   <= d_ff[k-1];
            big_ff[k] <= big_ff[k-1];
         end
      end
   end

   assign q   = q_ff[QBITS];
   assign big = big_ff[QBITS];

endmodule

>>> sv/dual_number_alu.sv
// Stages from req acceptance to rsp valid: 2 front stages, 34 divider
// stages, 1 output register. Throughput: one transaction per cycle unless
// rsp is held; the 34-stage divider pipe sets the depth. A held rsp stalls
// every stage together, nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// dual_number_alu
// Add, sub, mul, div, negate, conjugate and inverse on Q-format dual numbers
// with truncation toward zero, saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
module dual_number_alu #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dna_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dna_pkg::rsp_type  rsp_data
);
   import dna_pkg::*;

   localparam int NRW = 32 + FRAC_BITS;
   localparam int NDW = 64 + FRAC_BITS;
   localparam int DRW = 32;
   localparam int DDW = 63;
   localparam int DLY = QBITS + 1;

   typedef struct packed {
      op_type   op;
      part_type rp;
      part_type dp;
      logic     negr;
      logic     negd;
      logic     dz;
   } side_type;

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   logic en;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- stage 1: products ----------------
   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic signed [31:0] s1_ar_ff, s1_ad_ff, s1_br_ff, s1_bd_ff;
   logic signed [63:0] s1_pa_ff, s1_pb_ff, s1_pc_ff, s1_ps_ff;
   logic signed [63:0] pa_in, pb_in, pc_in, ps_in;
   logic signed [31:0] sq_in;

   assign sq_in = (op_type'(req_data.operation) == OP_INV) ? req_data.a_real : req_data.b_real;
   assign pa_in = req_data.a_real * req_data.b_real;
   assign pb_in = req_data.a_dual * req_data.b_real;
   assign pc_in = req_data.a_real * req_data.b_dual;
   assign ps_in = sq_in * sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff <= op_type'(req_data.operation);
         s1_ar_ff <= req_data.a_real;
         s1_ad_ff <= req_data.a_dual;
         s1_br_ff <= req_data.b_real;
         s1_bd_ff <= req_data.b_dual;
         s1_pa_ff <= pa_in;
         s1_pb_ff <= pb_in;
         s1_pc_ff <= pc_in;
         s1_ps_ff <= ps_in;
      end
   end

   // ---------------- stage 2: sums, operand setup ----------------
   logic signed [65:0] ar_x, ad_x, br_x, bd_x, pa_x, pb_x, pc_x, num_x;
   logic [65:0]        num_m;
   assign ar_x  = s1_ar_ff;
   assign ad_x  = s1_ad_ff;
   assign br_x  = s1_br_ff;
   assign bd_x  = s1_bd_ff;
   assign pa_x  = s1_pa_ff;
   assign pb_x  = s1_pb_ff;
   assign pc_x  = s1_pc_ff;
   assign num_x = pb_x - pc_x;
   assign num_m = num_x[65] ? 66'(-num_x) : 66'(num_x);

   side_type        side_in;
   logic [NRW-1:0]  nr_in;
   logic [DRW-1:0]  dr_in;
   logic [NDW-1:0]  nd_in;
   logic [DDW-1:0]  dd_in;

   always_comb begin
      side_in    = '0;
      side_in.op = s1_op_ff;
      nr_in      = '0;
      dr_in      = '0;
      nd_in      = '0;
      dd_in      = '0;
      case (s1_op_ff)
         OP_ADD: begin
            side_in.rp = mag_part(ar_x + br_x, 0);
            side_in.dp = mag_part(ad_x + bd_x, 0);
         end
         OP_SUB: begin
            side_in.rp = mag_part(ar_x - br_x, 0);
            side_in.dp = mag_part(ad_x - bd_x, 0);
         end
         OP_MUL: begin
            side_in.rp = mag_part(pa_x, FRAC_BITS);
            side_in.dp = mag_part(pb_x + pc_x, FRAC_BITS);
         end
         OP_NEG: begin
            side_in.rp = mag_part(-ar_x, 0);
            side_in.dp = mag_part(-ad_x, 0);
         end
         OP_CONJ: begin
            side_in.rp = mag_part(ar_x, 0);
            side_in.dp = mag_part(-ad_x, 0);
         end
         OP_DIV: begin
            side_in.dz   = (s1_br_ff == 32'sd0);
            side_in.negr = s1_ar_ff[31] ^ s1_br_ff[31];
            side_in.negd = num_x[65];
            nr_in        = NRW'(abs32(s1_ar_ff)) << FRAC_BITS;
            dr_in        = abs32(s1_br_ff);
            nd_in        = NDW'(num_m[63:0]) << FRAC_BITS;
            dd_in        = s1_ps_ff[DDW-1:0];
         end
         OP_INV: begin
            side_in.dz   = (s1_ar_ff == 32'sd0);
            side_in.negr = s1_ar_ff[31];
            side_in.negd = !s1_ad_ff[31] && (s1_ad_ff != 32'sd0);
            nr_in        = NRW'(1) << (2 * FRAC_BITS);
            dr_in        = abs32(s1_ar_ff);
            nd_in        = NDW'(abs32(s1_ad_ff)) << (2 * FRAC_BITS);
            dd_in        = s1_ps_ff[DDW-1:0];
         end
         default: begin
         end
      endcase
   end

   logic           s2_valid_ff;
   side_type       s2_side_ff;
   logic [NRW-1:0] s2_nr_ff;
   logic [DRW-1:0] s2_dr_ff;
   logic [NDW-1:0] s2_nd_ff;
   logic [DDW-1:0] s2_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff <= side_in;
         s2_nr_ff   <= nr_in;
         s2_dr_ff   <= dr_in;
         s2_nd_ff   <= nd_in;
         s2_dd_ff   <= dd_in;
      end
   end

   // ---------------- divider stages ----------------
   logic [QBITS-1:0] qr, qd;
   logic             bigr, bigd;

   dna_divider #(.NW(NRW), .DW(DRW)) u_div_real (
      .clock (clock),
      .en    (en),
      .n     (s2_nr_ff),
      .d     (s2_dr_ff),
      .q     (qr),
      .big   (bigr)
   );

   dna_divider #(.NW(NDW), .DW(DDW)) u_div_dual (
      .clock (clock),
      .en    (en),
      .n     (s2_nd_ff),
      .d     (s2_dd_ff),
      .q     (qd),
      .big   (bigd)
   );

   logic     vld_ff  [0:DLY-1];
   side_type side_ff [0:DLY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= s2_valid_ff;
         for (int k = 1; k < DLY; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s2_side_ff;
         for (int k = 1; k < DLY; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // ---------------- output stage ----------------
   side_type    sd;
   rsp_type     rsp_in;
   logic [32:0] sr, sdl;

   assign sd = side_ff[DLY-1];

   always_comb begin
      rsp_in = '0;
      sr     = '0;
      sdl    = '0;
      case (sd.op) inside
         OP_DIV, OP_INV: begin
            if (sd.dz) begin
               rsp_in.div_zero = 1'b1;
            end else begin
               sr  = sat32('{neg: sd.negr, mag: qr, big: bigr});
               sdl = sat32('{neg: sd.negd, mag: qd, big: bigd});
            end
         end
         default: begin
            sr  = sat32(sd.rp);
            sdl = sat32(sd.dp);
         end
      endcase
      rsp_in.res_real = sr[31:0];
      rsp_in.res_dual = sdl[31:0];
      rsp_in.overflow = sr[32] | sdl[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |->
         rsp_data.res_real == 32'sd0 && rsp_data.res_dual == 32'sd0 && !rsp_data.overflow)
      else $error("div_zero transaction with nonzero result");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.res_real == Q_MAX || rsp_data.res_real == Q_MIN ||
         rsp_data.res_dual == Q_MAX || rsp_data.res_dual == Q_MIN)
      else $error("overflow without saturated part");

   a_dz_op: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DLY-1] && sd.dz |-> sd.op == OP_DIV || sd.op == OP_INV)
      else $error("zero divisor flag on non-divide op");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff[DLY-1]) && $stable(s2_valid_ff))
      else $error("pipeline moved during stall");

endmodule
